// ===== rtl/efg_pkg.sv =====
// ----------------------------------------------------------------------------
// efg_pkg
// Types, codes and the flag check shared by the event flag group engine.
// ----------------------------------------------------------------------------
package efg_pkg;

    localparam int NUM_WAITERS = 16;
    localparam int FLAG_BITS   = 32;
    localparam int CNT_W       = $clog2(NUM_WAITERS + 1);

    // function codes
    localparam logic [2:0] FUNC_WAIT    = 3'd0;
    localparam logic [2:0] FUNC_TRY     = 3'd1;
    localparam logic [2:0] FUNC_SET     = 3'd2;
    localparam logic [2:0] FUNC_CLEAR   = 3'd3;
    localparam logic [2:0] FUNC_DESTROY = 3'd4;
    localparam logic [2:0] FUNC_LOAD    = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_DELETED = 2'd3;

    typedef logic [FLAG_BITS-1:0] flag_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  task_id;
        logic        want_set;
        logic        want_all;
        logic        consume;
        logic [31:0] mask;
    } in_t;

    typedef struct packed {
        logic [7:0]  task_id_res;
        logic [1:0]  status;
        logic [31:0] result_flags;
        logic        woken;
        logic [31:0] flags_now;
        logic [4:0]  waiter_count;
        logic        last;
    } out_t;

    // one waiter entry; mode bit 0 want_set, bit 1 want_all, bit 2 consume
    typedef struct packed {
        logic       used;
        logic       woken;
        logic [7:0] task_id;
        flag_t      mask;
        logic [2:0] mode;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef struct packed {
        logic  pass;
        flag_t cal;
        flag_t flags;
    } chk_t;

    // test a mask against the flags and apply consume on a pass
    function automatic chk_t efg_check(flag_t flags, logic [2:0] mode, flag_t mask);
        chk_t r;
        r.cal   = mode[0] ? (flags & mask) : (~flags & mask);
        r.pass  = mode[1] ? (r.cal == mask) : (r.cal != '0);
        r.flags = flags;
        if (r.pass && mode[2]) begin
            r.flags = mode[0] ? (flags & ~mask) : (flags | mask);
        end
        return r;
    endfunction

endpackage

// ===== rtl/efg_cell.sv =====
// ----------------------------------------------------------------------------
// efg_cell
// One waiter slot of the queue: takes its upper neighbor on a shift, or a
// fed-back or appended entry on a load.
// ----------------------------------------------------------------------------
module efg_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  efg_pkg::cell_ctl_t ctl,
    input  efg_pkg::entry_t    nbr,
    input  efg_pkg::entry_t    feed,
    output efg_pkg::entry_t    ent
);
    import efg_pkg::*;

    entry_t ent_reg;

    // load wins over shift so a kept head lands at the tail
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.used  <= 1'b0;
            ent_reg.woken <= 1'b0;
        end else if (ctl.load) begin
            ent_reg <= feed;
        end else if (ctl.shift) begin
            ent_reg <= nbr;
        end
    end

    assign ent = ent_reg;

endmodule

// ===== rtl/event_flag_group_engine.sv =====
// ----------------------------------------------------------------------------
// event_flag_group_engine
// Event flag word with an ordered queue of waiting tasks.
// ----------------------------------------------------------------------------
// Waiters sit in a row of cells that shifts toward the head; the head entry
// is checked and either dropped or written back behind the last one, so a
// full pass over n waiters keeps their order. Wait, try, load and unknown
// functions give a result straight from the idle state. A post walks the
// queue, then hands out wakeups (one per cycle while the result side keeps
// up) and then the caller's result. Destroy skips the walk. Every result of
// an input carries the flag word and waiter count as they stand after that
// input is done.
module event_flag_group_engine (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  efg_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output efg_pkg::out_t  m_data
);
    import efg_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    logic [1:0] state_reg;
    flag_t      flag_reg;
    cnt_t       cnt_reg;
    cnt_t       iter_reg;
    cnt_t       wait_cnt_reg;
    logic [2:0] func_reg;
    logic [7:0] tid_reg;
    out_t       out_reg;
    out_t       out_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    entry_t     ent [NUM_WAITERS];
    cell_ctl_t  ctl [NUM_WAITERS];
    entry_t     feed;
    entry_t     head;
    entry_t     kept;
    chk_t       head_chk;
    chk_t       in_chk;
    flag_t      in_mask;
    logic       out_free;
    logic       take;
    logic       shift_en;
    logic       keep_en;
    logic       app_en;
    logic       drop;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign take     = s_valid && s_ready;
    assign in_mask  = s_data.mask[FLAG_BITS-1:0];
    assign in_chk   = efg_check(flag_reg, {s_data.consume, s_data.want_all, s_data.want_set},
                                in_mask);
    assign head     = ent[0];
    assign head_chk = efg_check(flag_reg, head.mode, head.mask);
    assign drop     = (func_reg == FUNC_DESTROY) || head.woken;

    // head entry written back after the walk check
    always_comb begin
        kept = head;
        if (state_reg == S_WALK && head_chk.pass) begin
            kept.woken = 1'b1;
            kept.mask  = head_chk.cal;
        end
    end

    // decide shift, write-back and append for this cycle
    always_comb begin
        shift_en = 1'b0;
        keep_en  = 1'b0;
        app_en   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                app_en = take && (s_data.func == FUNC_WAIT) && !in_chk.pass
                         && (cnt_reg < CNT_W'(NUM_WAITERS));
            end
            S_WALK: begin
                if (iter_reg != '0) begin
                    shift_en = 1'b1;
                    keep_en  = 1'b1;
                end
            end
            S_EMIT: begin
                if (iter_reg != '0) begin
                    if (!drop) begin
                        shift_en = 1'b1;
                        keep_en  = 1'b1;
                    end else if (out_free) begin
                        shift_en = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        feed = kept;
        if (app_en) begin
            feed.used    = 1'b1;
            feed.woken   = 1'b0;
            feed.task_id = s_data.task_id;
            feed.mask    = in_mask;
            feed.mode    = {s_data.consume, s_data.want_all, s_data.want_set};
        end
    end

    // row of waiter cells
    for (genvar i = 0; i < NUM_WAITERS; i++) begin : g_cell
        entry_t nbr;
        if (i == NUM_WAITERS - 1) begin : g_end
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = ent[i+1];
        end
        assign ctl[i].shift = shift_en;
        assign ctl[i].load  = (keep_en && (cnt_reg - 1'b1 == CNT_W'(i)))
                              || (app_en && (cnt_reg == CNT_W'(i)));
        efg_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl[i]),
            .nbr     (nbr),
            .feed    (feed),
            .ent     (ent[i])
        );
    end

    // build the next result transfer
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        case (state_reg)
            S_IDLE: begin
                if (take) begin
                    out_next.task_id_res  = s_data.task_id;
                    out_next.status       = ST_OK;
                    out_next.result_flags = '0;
                    out_next.woken        = 1'b0;
                    out_next.flags_now    = 32'(flag_reg);
                    out_next.waiter_count = 5'(cnt_reg);
                    out_next.last         = 1'b1;
                    case (s_data.func)
                        FUNC_WAIT: begin
                            out_valid_next        = 1'b1;
                            out_next.result_flags = 32'(in_chk.cal);
                            out_next.flags_now    = 32'(in_chk.flags);
                            if (!in_chk.pass) begin
                                if (app_en) begin
                                    out_next.waiter_count = 5'(cnt_reg + 1'b1);
                                    out_next.status       = ST_PENDING;
                                end else begin
                                    out_next.status = ST_FULL;
                                end
                            end
                        end
                        FUNC_TRY: begin
                            out_valid_next        = 1'b1;
                            out_next.result_flags = 32'(in_chk.cal);
                            out_next.flags_now    = 32'(in_chk.flags);
                            out_next.status       = in_chk.pass ? ST_OK : ST_PENDING;
                        end
                        FUNC_SET, FUNC_CLEAR, FUNC_DESTROY: ;
                        FUNC_LOAD: begin
                            out_valid_next     = 1'b1;
                            out_next.flags_now = 32'(in_mask);
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (iter_reg != '0 && drop && out_free) begin
                    out_valid_next        = 1'b1;
                    out_next.task_id_res  = head.task_id;
                    out_next.status       = (func_reg == FUNC_DESTROY) ? ST_DELETED : ST_OK;
                    out_next.result_flags = 32'(head.mask);
                    out_next.woken        = 1'b1;
                    out_next.flags_now    = 32'(flag_reg);
                    out_next.waiter_count = 5'(wait_cnt_reg);
                    out_next.last         = 1'b0;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    out_valid_next        = 1'b1;
                    out_next.task_id_res  = tid_reg;
                    out_next.status       = ST_OK;
                    out_next.result_flags = '0;
                    out_next.woken        = 1'b0;
                    out_next.flags_now    = 32'(flag_reg);
                    out_next.waiter_count = 5'(wait_cnt_reg);
                    out_next.last         = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // hold the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // sequence the walk, the wakeup pass and the results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            flag_reg      <= '0;
            cnt_reg       <= '0;
            iter_reg      <= '0;
            wait_cnt_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        func_reg <= s_data.func;
                        tid_reg  <= s_data.task_id;
                        case (s_data.func)
                            FUNC_WAIT: begin
                                flag_reg <= in_chk.flags;
                                if (app_en) begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                end
                            end
                            FUNC_TRY: begin
                                flag_reg <= in_chk.flags;
                            end
                            FUNC_SET: begin
                                flag_reg     <= flag_reg | in_mask;
                                iter_reg     <= cnt_reg;
                                wait_cnt_reg <= cnt_reg;
                                state_reg    <= S_WALK;
                            end
                            FUNC_CLEAR: begin
                                flag_reg     <= flag_reg & ~in_mask;
                                iter_reg     <= cnt_reg;
                                wait_cnt_reg <= cnt_reg;
                                state_reg    <= S_WALK;
                            end
                            FUNC_DESTROY: begin
                                iter_reg     <= cnt_reg;
                                wait_cnt_reg <= '0;
                                state_reg    <= S_EMIT;
                            end
                            FUNC_LOAD: begin
                                flag_reg <= in_mask;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    if (iter_reg == '0) begin
                        iter_reg  <= cnt_reg;
                        state_reg <= S_EMIT;
                    end else begin
                        iter_reg <= iter_reg - 1'b1;
                        if (head_chk.pass) begin
                            flag_reg     <= head_chk.flags;
                            wait_cnt_reg <= wait_cnt_reg - 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (iter_reg == '0) begin
                        state_reg <= S_FINAL;
                    end else if (!drop) begin
                        iter_reg <= iter_reg - 1'b1;
                    end else if (out_free) begin
                        iter_reg <= iter_reg - 1'b1;
                        cnt_reg  <= cnt_reg - 1'b1;
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/efg_checker.sv =====
// ----------------------------------------------------------------------------
// efg_checker
// Port-level checks on the event flag group engine, bound to the top level.
// ----------------------------------------------------------------------------
module efg_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input efg_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input efg_pkg::out_t m_data
);
    import efg_pkg::*;

    // hold a stalled result transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // accept input only when the result register can drain
    a_in_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input taken over a stalled result");

    // never report more waiters than slots
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.waiter_count <= 5'(NUM_WAITERS))
        else $error("waiter count out of range");

    // a wakeup is never marked as the caller's final result
    a_woken_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.woken |-> !m_data.last)
        else $error("wakeup marked as final result");

endmodule

bind event_flag_group_engine efg_checker u_efg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
